FILE: sv/rfbl_pkg.sv
// Package for the rotating FIFO bank level: sizes, operation and status codes,
// and the command word passed from the front end to the back end.
// No dependencies.
package rfbl_pkg;

	localparam int NUM_FIFOS   = 10;
	localparam int FIFO_DEPTH  = 64;
	localparam int DESC_WIDTH  = 32;

	localparam int IDX_W       = $clog2(NUM_FIFOS);
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W      = $clog2(NUM_FIFOS * FIFO_DEPTH);
	localparam int CFG_W       = 4;
	localparam int CMP_W       = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

	// fixed port widths
	localparam int OP_W        = 2;
	localparam int PKT_W       = 32;
	localparam int FIDX_W      = 4;
	localparam int CSIZE_W     = 7;
	localparam int STAT_W      = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_ADV = 2'd2,
		OP_SET = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADIDX = 2'd3
	} status_t;

	typedef struct packed {
		logic                  wr_en;
		logic                  rd_en;
		logic [ADDR_W-1:0]     addr;
		logic [DESC_WIDTH-1:0] wdata;
		status_t               status;
		logic [IDX_W-1:0]      cur_index;
		logic [CNT_W-1:0]      cur_size;
		logic                  cur_empty;
	} cmd_t;

endpackage

FILE: sv/rfbl_front.sv
// Front end of the FIFO bank level: accepts operations, keeps the per-FIFO
// head/tail/count state and the serving pointer, and issues commands.
// Depends on rfbl_pkg.
module rfbl_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rfbl_pkg::CFG_W-1:0] fifos_in_use,
	input  logic                       in_valid,
	input  logic [rfbl_pkg::OP_W-1:0]  op_in,
	input  logic [rfbl_pkg::PKT_W-1:0] pkt_in,
	input  logic [rfbl_pkg::FIDX_W-1:0] idx_in,
	input  logic                       q_full,
	output logic                       push,
	output rfbl_pkg::cmd_t             cmd
);
	import rfbl_pkg::*;

	logic [PTR_W-1:0] head_q [NUM_FIFOS];
	logic [PTR_W-1:0] tail_q [NUM_FIFOS];
	logic [CNT_W-1:0] count_q [NUM_FIFOS];
	logic [IDX_W-1:0] sp_q;
	logic [CNT_W-1:0] cur_cnt_q;

	op_t              op;
	logic             idx_ok;
	logic [IDX_W-1:0] idx;
	logic [CMP_W-1:0] vol;
	logic [IDX_W-1:0] next_sp;
	logic [IDX_W-1:0] tgt;
	logic [CNT_W-1:0] cnt_t;
	logic [PTR_W-1:0] head_t;
	logic [PTR_W-1:0] tail_t;

	logic             wr_head;
	logic             wr_tail;
	logic             wr_cnt;
	logic [PTR_W-1:0] head_n;
	logic [PTR_W-1:0] tail_n;
	logic [CNT_W-1:0] cnt_n;
	logic [IDX_W-1:0] sp_n;
	logic [CNT_W-1:0] cur_cnt_n;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign op     = op_t'(op_in);
	assign idx_ok = idx_in < FIDX_W'(NUM_FIFOS);
	assign idx    = idx_ok ? IDX_W'(idx_in) : '0;
	assign push   = in_valid && !q_full;

	// rotation count capped at the bank size
	always_comb begin
		vol = CMP_W'(fifos_in_use);
		if (vol > CMP_W'(NUM_FIFOS))
			vol = CMP_W'(NUM_FIFOS);
		next_sp = ((CMP_W'(sp_q) + CMP_W'(1)) < vol) ? sp_q + IDX_W'(1) : '0;
	end

	// one FIFO is touched per operation
	always_comb begin
		case (op)
			OP_ENQ:  tgt = idx;
			OP_DEQ:  tgt = sp_q;
			OP_ADV:  tgt = next_sp;
			default: tgt = idx;
		endcase
	end

	assign cnt_t  = count_q[tgt];
	assign head_t = head_q[tgt];
	assign tail_t = tail_q[tgt];

	always_comb begin
		wr_head   = 1'b0;
		wr_tail   = 1'b0;
		wr_cnt    = 1'b0;
		head_n    = next_slot(head_t);
		tail_n    = next_slot(tail_t);
		cnt_n     = cnt_t;
		sp_n      = sp_q;
		cur_cnt_n = cur_cnt_q;
		cmd       = '0;
		cmd.status = ST_OK;
		cmd.wdata = DESC_WIDTH'(pkt_in);
		case (op)
			OP_ENQ: begin
				cmd.addr = ADDR_W'(idx) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(tail_t);
				if (!idx_ok) begin
					cmd.status = ST_BADIDX;
				end else if (cnt_t >= CNT_W'(FIFO_DEPTH)) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.wr_en = 1'b1;
					wr_tail   = 1'b1;
					wr_cnt    = 1'b1;
					cnt_n     = cnt_t + CNT_W'(1);
					if (idx == sp_q)
						cur_cnt_n = cnt_t + CNT_W'(1);
				end
			end
			OP_DEQ: begin
				cmd.addr = ADDR_W'(sp_q) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_t);
				if (cnt_t == '0) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.rd_en = 1'b1;
					wr_head   = 1'b1;
					wr_cnt    = 1'b1;
					cnt_n     = cnt_t - CNT_W'(1);
					cur_cnt_n = cnt_t - CNT_W'(1);
				end
			end
			OP_ADV: begin
				sp_n      = next_sp;
				cur_cnt_n = cnt_t;
			end
			default: begin
				if (!idx_ok) begin
					cmd.status = ST_BADIDX;
				end else begin
					sp_n      = idx;
					cur_cnt_n = cnt_t;
				end
			end
		endcase
		cmd.cur_index = sp_n;
		cmd.cur_size  = cur_cnt_n;
		cmd.cur_empty = (cur_cnt_n == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			cur_cnt_q <= '0;
			for (int i = 0; i < NUM_FIFOS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (push) begin
			sp_q      <= sp_n;
			cur_cnt_q <= cur_cnt_n;
			if (wr_head)
				head_q[tgt] <= head_n;
			if (wr_tail)
				tail_q[tgt] <= tail_n;
			if (wr_cnt)
				count_q[tgt] <= cnt_n;
		end
	end

endmodule

FILE: sv/rfbl_queue.sv
// Short command queue decoupling the front end from the back end.
// Depends on rfbl_pkg.
module rfbl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rfbl_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output rfbl_pkg::cmd_t head_cmd
);
	import rfbl_pkg::*;

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;

	assign full     = (count_q == QC_W'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			if (push && !pop)
				count_q <= count_q + QC_W'(1);
			else if (pop && !push)
				count_q <= count_q - QC_W'(1);
		end
	end

endmodule

FILE: sv/rfbl_back.sv
// Back end of the FIFO bank level: descriptor memory access and the output
// register holding the result transaction.
// Depends on rfbl_pkg.
module rfbl_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rfbl_pkg::cmd_t                q_cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rfbl_pkg::PKT_W-1:0]    pkt_out,
	output logic                          pkt_valid,
	output logic [rfbl_pkg::STAT_W-1:0]   stat,
	output logic [rfbl_pkg::FIDX_W-1:0]   cur_index,
	output logic [rfbl_pkg::CSIZE_W-1:0]  cur_size,
	output logic                          cur_empty
);
	import rfbl_pkg::*;

	logic [DESC_WIDTH-1:0] mem [NUM_FIFOS * FIFO_DEPTH];
	logic [DESC_WIDTH-1:0] rd_data_s1;
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic                  adv_s1;

	logic                  valid_s2;
	logic [DESC_WIDTH-1:0] pkt_s2;
	cmd_t                  cmd_s2;

	assign adv_s1 = !valid_s2 || !out_stall;
	assign pop    = q_valid && (!valid_s1 || adv_s1);

	always_ff @(posedge clk) begin
		if (pop && q_cmd.wr_en)
			mem[q_cmd.addr] <= q_cmd.wdata;
		if (pop && q_cmd.rd_en)
			rd_data_s1 <= mem[q_cmd.addr];
		if (pop)
			cmd_s1 <= q_cmd;
		if (valid_s1 && adv_s1) begin
			cmd_s2 <= cmd_s1;
			pkt_s2 <= cmd_s1.rd_en ? rd_data_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (valid_s1 && adv_s1)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	assign out_valid = valid_s2;
	assign pkt_out   = PKT_W'(pkt_s2);
	assign pkt_valid = cmd_s2.rd_en;
	assign stat      = cmd_s2.status;
	assign cur_index = FIDX_W'(cmd_s2.cur_index);
	assign cur_size  = CSIZE_W'(cmd_s2.cur_size);
	assign cur_empty = cmd_s2.cur_empty;

endmodule

FILE: sv/rotating_fifo_bank_level_unit.sv
// One level of a calendar-queue scheduler: ten descriptor FIFOs of 64 entries
// with a serving pointer. Enqueue, dequeue, advance and set operations are
// taken at up to one per cycle while in_stall is low, and each yields one
// result transaction; the front end computes pointer and count updates
// combinationally and registers them on acceptance, a four-entry command
// queue feeds the back end with a descriptor memory stage and an output register.
// in_stall rises only when that queue fills because out_stall is held.
// Depends on rfbl_pkg, rfbl_front, rfbl_queue and rfbl_back.
module rotating_fifo_bank_level_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rfbl_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rfbl_pkg::OP_W-1:0]     operation,
	input  logic [rfbl_pkg::PKT_W-1:0]    packet_in,
	input  logic [rfbl_pkg::FIDX_W-1:0]   fifo_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rfbl_pkg::PKT_W-1:0]    packet_out,
	output logic                          packet_valid,
	output logic [rfbl_pkg::STAT_W-1:0]   status,
	output logic [rfbl_pkg::FIDX_W-1:0]   current_index,
	output logic [rfbl_pkg::CSIZE_W-1:0]  current_size,
	output logic                          current_empty
);
	import rfbl_pkg::*;

	logic [CFG_W-1:0] fifos_in_use_q;
	logic             q_full;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	logic             q_valid;
	cmd_t             head_cmd;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fifos_in_use_q <= CFG_RESET;
		else if (cfg_valid && cfg_ready)
			fifos_in_use_q <= cfg_data;
	end

	rfbl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifos_in_use (fifos_in_use_q),
		.in_valid     (in_valid),
		.op_in        (operation),
		.pkt_in       (packet_in),
		.idx_in       (fifo_index),
		.q_full       (q_full),
		.push         (push),
		.cmd          (push_cmd)
	);

	rfbl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head_cmd (head_cmd)
	);

	rfbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pkt_out   (packet_out),
		.pkt_valid (packet_valid),
		.stat      (status),
		.cur_index (current_index),
		.cur_size  (current_size),
		.cur_empty (current_empty)
	);

endmodule
